[design/bec_pkg.sv]
// ---------------------------------------------------------------------------
// bec_pkg: shared types and functions for the byte escape encoder
// Holds the escape-run descriptor type, character constants and the
// classification function that turns one raw byte into its escaped text.
// ---------------------------------------------------------------------------
package bec_pkg;

    localparam int unsigned RUN_MAX   = 6;
    localparam int unsigned LEN_W     = $clog2(RUN_MAX + 1);
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_BSL     = 8'd92;   // backslash
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_SQUOTE  = 8'd39;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_ZERO    = 8'd48;   // '0'
    localparam logic [7:0] CH_LT      = 8'd60;   // '<'
    localparam logic [7:0] CH_GT      = 8'd62;   // '>'
    localparam logic [7:0] CTRL_LO    = 8'd7;
    localparam logic [7:0] CTRL_END   = 8'd14;

    // letters for bytes 7..13: a b t n v f r
    localparam logic [7:0] CTRL_LETTERS [7] = '{
        8'd97, 8'd98, 8'd116, 8'd110, 8'd118, 8'd102, 8'd114
    };

    // one escaped run: chars[0] goes out first
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [LEN_W-1:0]        len;
        logic                    final_mark;
    } t_run;

    // classify one byte and build its escaped run
    function automatic t_run build_run(input logic [7:0] b, input logic fin);
        t_run        run;
        logic [1:0]  hund;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [2:0]  letter_idx;
        logic [7:0]  ctrl_off;
        run            = '0;
        run.final_mark = fin;

        // decimal digits: hundreds by compare, tens by reciprocal multiply
        hund = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
        case (hund)
            2'd2:    rem = 7'(b - 8'd200);
            2'd1:    rem = 7'(b - 8'd100);
            default: rem = b[6:0];
        endcase
        prod = 15'(rem) * 15'd205;
        tens = prod[14:11];
        ones = 4'(rem - 7'(tens) * 7'd10);

        ctrl_off   = b - CTRL_LO;
        letter_idx = ctrl_off[2:0];

        if (b == 8'd0) begin
            run.chars[0] = CH_BSL;
            run.chars[1] = CH_ZERO;
            run.len      = LEN_W'(2);
        end else if (b >= CTRL_LO && b < CTRL_END) begin
            run.chars[0] = CH_BSL;
            run.chars[1] = CTRL_LETTERS[letter_idx];
            run.len      = LEN_W'(2);
        end else if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BSL) begin
            run.chars[0] = CH_BSL;
            run.chars[1] = b;
            run.len      = LEN_W'(2);
        end else if (b >= CH_SPACE && b < CH_DEL) begin
            run.chars[0] = b;
            run.len      = LEN_W'(1);
        end else if (b >= 8'd100) begin
            run.chars[0] = CH_BSL;
            run.chars[1] = CH_LT;
            run.chars[2] = CH_ZERO + 8'(hund);
            run.chars[3] = CH_ZERO + 8'(tens);
            run.chars[4] = CH_ZERO + 8'(ones);
            run.chars[5] = CH_GT;
            run.len      = LEN_W'(6);
        end else if (b >= 8'd10) begin
            run.chars[0] = CH_BSL;
            run.chars[1] = CH_LT;
            run.chars[2] = CH_ZERO + 8'(tens);
            run.chars[3] = CH_ZERO + 8'(ones);
            run.chars[4] = CH_GT;
            run.len      = LEN_W'(5);
        end else begin
            run.chars[0] = CH_BSL;
            run.chars[1] = CH_LT;
            run.chars[2] = CH_ZERO + 8'(ones);
            run.chars[3] = CH_GT;
            run.len      = LEN_W'(4);
        end
        return run;
    endfunction

endpackage

[design/bec_front.sv]
// ---------------------------------------------------------------------------
// bec_front: input stage
// Accepts one raw byte per word, classifies it and registers the escaped
// run descriptor for the queue.
// ---------------------------------------------------------------------------
module bec_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_final,
    output logic          o_valid,
    input  logic          i_ready,
    output bec_pkg::t_run o_run
);
    import bec_pkg::*;

    logic r_valid;
    t_run r_run;
    logic take;

    // stage is free when empty or when its word moves on this cycle
    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // descriptor register, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_run <= build_run(i_byte, i_final);
        end
    end

    assign o_valid = r_valid;
    assign o_run   = r_run;

endmodule

[design/bec_queue.sv]
// ---------------------------------------------------------------------------
// bec_queue: descriptor queue
// Short FIFO of run descriptors between the front and back stages.
// ---------------------------------------------------------------------------
module bec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bec_pkg::t_run i_run,
    output logic          o_valid,
    input  logic          i_ready,
    output bec_pkg::t_run o_run
);
    import bec_pkg::*;

    t_run                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                push;
    logic                pop;

    assign o_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_run   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

endmodule

[design/bec_back.sv]
// ---------------------------------------------------------------------------
// bec_back: output serializer
// Pops run descriptors and emits their characters one word per cycle while
// the output is taken, through a registered output.
// ---------------------------------------------------------------------------
module bec_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bec_pkg::t_run i_run,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_run_last,
    output logic          o_text_last
);
    import bec_pkg::*;

    logic [RUN_MAX-1:0][7:0] r_chars;
    logic [RUN_MAX-1:0][7:0] n_chars;
    logic [LEN_W-1:0]        r_left;
    logic [LEN_W-1:0]        n_left;
    logic                    r_final;
    logic                    n_final;
    logic                    r_ovalid;
    logic [7:0]              r_obyte;
    logic                    r_orun_last;
    logic                    r_otext_last;
    logic                    load;
    logic                    emit;
    logic                    last_emit;
    logic                    pop;

    // output register frees up when empty or taken
    assign load      = !r_ovalid || i_ready;
    assign emit      = load && (r_left != '0);
    assign last_emit = emit && (r_left == LEN_W'(1));
    assign pop       = i_valid && ((r_left == '0) || last_emit);
    assign o_ready   = (r_left == '0) || last_emit;

    // next run state: take a new descriptor or shift out one char
    always_comb begin
        n_chars = r_chars;
        n_left  = r_left;
        n_final = r_final;
        if (pop) begin
            n_chars = i_run.chars;
            n_left  = i_run.len;
            n_final = i_run.final_mark;
        end else if (emit) begin
            n_chars = {8'h00, r_chars[RUN_MAX-1:1]};
            n_left  = r_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_left <= n_left;
            if (load) begin
                r_ovalid <= emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        r_final <= n_final;
        if (emit) begin
            r_obyte      <= r_chars[0];
            r_orun_last  <= (r_left == LEN_W'(1));
            r_otext_last <= (r_left == LEN_W'(1)) && r_final;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_byte      = r_obyte;
    assign o_run_last  = r_orun_last;
    assign o_text_last = r_otext_last;

endmodule

[design/byte_escape_encoder.sv]
// ---------------------------------------------------------------------------
// byte_escape_encoder: C-style string escape encoder
// Turns each raw input byte into its escaped text, one output word per char.
// ---------------------------------------------------------------------------
// Each input byte yields a run of 1 to 6 output bytes: NUL as \0, bytes 7..13
// as \a \b \t \n \v \f \r, quotes and backslash prefixed by a backslash,
// other printable bytes unchanged, and all remaining bytes as \<decimal>.
// The output port moves one byte per cycle while i_m_axis_tready is high;
// input bytes are taken every cycle while the two-entry descriptor queue
// and front register have room. tuser flags the last byte of each run,
// tlast the last byte of the whole string.
module byte_escape_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // in_final
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] o_m_axis_tuser,   // [0] run_last
    output logic       o_m_axis_tlast    // text_last
);
    import bec_pkg::*;

    logic f_valid;
    logic f_ready;
    t_run f_run;
    logic q_valid;
    logic q_ready;
    t_run q_run;

    // front: accept and classify
    bec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_final (i_s_axis_tlast),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_run   (f_run)
    );

    // descriptor queue
    bec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_run   (f_run),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_run   (q_run)
    );

    // back: serialize runs
    bec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_run       (q_run),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_run_last  (o_m_axis_tuser[0]),
        .o_text_last (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    // end of string is always also end of a run
    a_tlast_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser[0])
        else $error("tlast without run end");

    // a run is emitted without gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tuser[0] |=> o_m_axis_tvalid)
        else $error("gap inside an escape run");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stream test of the byte escape encoder
// Feeds raw string bytes with random bursts and gaps, stalls the output on a
// shifting pattern, and checks every output word against the escaped text
// predicted independently for each accepted byte.
// ---------------------------------------------------------------------------
module testbench;

    // character codes used by the escape predictor
    localparam logic [7:0] CHR_BACKSLASH = 8'd92;
    localparam logic [7:0] CHR_DQUOTE    = 8'd34;
    localparam logic [7:0] CHR_SQUOTE    = 8'd39;
    localparam logic [7:0] CHR_SPACE     = 8'd32;
    localparam logic [7:0] CHR_DEL       = 8'd127;
    localparam logic [7:0] CHR_DIGIT0    = 8'd48;
    localparam logic [7:0] CHR_OPEN      = 8'd60;   // '<'
    localparam logic [7:0] CHR_CLOSE     = 8'd62;   // '>'
    localparam logic [7:0] CTRL_FIRST    = 8'd7;
    localparam logic [7:0] CTRL_PAST     = 8'd14;
    localparam logic [7:0] ESC_LETTERS [7] = '{
        8'd97, 8'd98, 8'd116, 8'd110, 8'd118, 8'd102, 8'd114   // a b t n v f r
    };
    localparam int         MAX_REPORTS   = 10;
    localparam int         RANDOM_BYTES  = 108;

    // one output word of escaped text
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_last;
    } t_esc_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;     // [7:0] in_byte
    logic       i_s_axis_tlast;     // in_final
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;     // [7:0] out_byte
    logic [0:0] o_m_axis_tuser;     // [0] run_last
    logic       o_m_axis_tlast;     // text_last

    byte_escape_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // escaped text of one raw byte; returns its length, run[0] goes first
    function automatic int escape_run(input logic [7:0] raw, output logic [5:0][7:0] run);
        int n;
        n   = 0;
        run = '0;
        if (raw == 8'd0) begin
            run[0] = CHR_BACKSLASH;
            run[1] = CHR_DIGIT0;
            n      = 2;
        end else if (raw >= CTRL_FIRST && raw < CTRL_PAST) begin
            run[0] = CHR_BACKSLASH;
            run[1] = ESC_LETTERS[raw - CTRL_FIRST];
            n      = 2;
        end else if (raw == CHR_DQUOTE || raw == CHR_SQUOTE || raw == CHR_BACKSLASH) begin
            run[0] = CHR_BACKSLASH;
            run[1] = raw;
            n      = 2;
        end else if (raw >= CHR_SPACE && raw < CHR_DEL) begin
            run[0] = raw;
            n      = 1;
        end else begin
            // numeric form: \<ddd> without leading zeros
            run[0] = CHR_BACKSLASH;
            run[1] = CHR_OPEN;
            n      = 2;
            if (raw >= 8'd100) begin
                run[n] = CHR_DIGIT0 + raw / 8'd100;
                n++;
            end
            if (raw >= 8'd10) begin
                run[n] = CHR_DIGIT0 + (raw / 8'd10) % 8'd10;
                n++;
            end
            run[n] = CHR_DIGIT0 + raw % 8'd10;
            n++;
            run[n] = CHR_CLOSE;
            n++;
        end
        return n;
    endfunction

    // holds the escaped words still owed by the encoder
    class escape_scoreboard;
        t_esc_word   owed_words[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_byte(logic [7:0] raw, logic fin);
            logic [5:0][7:0] run;
            t_esc_word       w;
            int              len;
            len = escape_run(raw, run);
            for (int k = 0; k < len; k++) begin
                w.out_byte  = run[k];
                w.run_last  = (k == len - 1);
                w.text_last = (k == len - 1) ? fin : 1'b0;
                owed_words.push_back(w);
            end
        endfunction

        function void check_word(t_esc_word got);
            t_esc_word want;
            if (owed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: byte=%0d run_last=%0b text_last=%0b",
                             got.out_byte, got.run_last, got.text_last);
                return;
            end
            want = owed_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: exp byte=%0d run_last=%0b text_last=%0b,",
                              " got byte=%0d run_last=%0b text_last=%0b"},
                             want.out_byte, want.run_last, want.text_last,
                             got.out_byte, got.run_last, got.text_last);
            end
        endfunction
    endclass

    escape_scoreboard sb = new();

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // monitor: note accepted bytes, check accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_word({o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast});
        end
    end

    // output stalls: ready low while stall_phase is below stall_len, phase wrapping at stall_period
    int stall_period = 1;
    int stall_len    = 0;
    int stall_phase  = 0;
    int stall_age    = 0;
    always @(negedge i_clk) begin
        if (stall_age == 0) begin
            stall_age    = 64;
            stall_period = $urandom_range(1, 8);
            stall_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
            stall_phase  = 0;
        end
        i_m_axis_tready <= (stall_phase >= stall_len);
        stall_phase = (stall_phase + 1) % stall_period;
        stall_age--;
    end

    // sender burst state
    int burst_left = 0;

    // present one byte and hold it until taken; returns at a falling edge
    task automatic send_byte(input logic [7:0] raw, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= raw;
        i_s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // byte with a bias toward each escape class
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'($urandom_range(0, 31));
            2:       return 8'($urandom_range(127, 255));
            3:       begin
                case ($urandom_range(0, 2))
                    0:       return CHR_BACKSLASH;
                    1:       return CHR_DQUOTE;
                    default: return CHR_SQUOTE;
                endcase
            end
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    logic [7:0] edge_bytes [22] = '{
        8'd0, 8'd1, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
        8'd31, 8'd32, 8'd34, 8'd39, 8'd92, 8'd99, 8'd100, 8'd126, 8'd127,
        8'd200, 8'd255
    };

    // main sequence
    initial begin
        int sent;
        int str_len;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: class boundaries, first byte alone as a one-byte string
        foreach (edge_bytes[i])
            send_byte(edge_bytes[i], (i == 0) || (i % 5 == 4) || (i == 21));

        // random strings of 1 to 12 bytes, final mark on the last
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            str_len = $urandom_range(1, 12);
            for (int k = 0; k < str_len; k++)
                send_byte(pick_byte(), k == str_len - 1);
            sent += str_len;
        end
        i_s_axis_tvalid <= 1'b0;

        // drain
        while (sb.owed_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.owed_words.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
